// File: rtl/core/fce_pkg.sv
package fce_pkg;

    // Default depth of the history line, in samples.
    localparam int MAX_DELAY_DEF = 65536;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SW_CODE_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;

    // Saturation width codes; the reserved code behaves like 32 bits.
    localparam logic [SW_CODE_W-1:0] SW_8  = 2'd0;
    localparam logic [SW_CODE_W-1:0] SW_16 = 2'd1;
    localparam logic [SW_CODE_W-1:0] SW_32 = 2'd2;

    // Q2.14 gain: the product is scaled down by this many bits.
    localparam int FRAC_BITS = 14;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } result_t;

endpackage

// File: rtl/core/feedback_comb_echo_core.sv
// Channel   Dir  Bits   Contents
// s_*       in   32/1   tdata: sample_in[31:0]; tuser: first[0]
// m_*       out  32/1   tdata: sample_out[31:0]; tuser: clipped[0]
// cfg_*     in   2/16   cfg_index selects delay_samples, decay_gain, sample_width
//
// One sample per cycle while m_tready is high; a beat is registered in s1, then out_reg.
// The history line is read when the beat is taken and the echo is computed in the
// next cycle; an echo one sample back is forwarded from the last write.
// Reset clears the configuration, pointer, fill count and valid flags; the history
// line needs no clearing pass because reads are gated by the fill count.
// While m_tready is low the result holds and the input stage still takes one beat.
module feedback_comb_echo_core #(
    parameter int MAX_DELAY = fce_pkg::MAX_DELAY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fce_pkg::SAMPLE_W-1:0]     s_tdata,   // sample_in[31:0]
    input  logic [0:0]                       s_tuser,   // first[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fce_pkg::SAMPLE_W-1:0]     m_tdata,   // sample_out[31:0]
    output logic [0:0]                       m_tuser,   // clipped[0]
    input  logic                             cfg_we,
    input  logic [fce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fce_pkg::CFG_W-1:0]        cfg_data
);

    import fce_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int FW = $clog2(MAX_DELAY + 1);
    localparam int DW = (FW > 16) ? FW : 16;
    localparam logic [DW-1:0] MAX_D     = DW'(MAX_DELAY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(MAX_DELAY);

    // Configuration.
    logic [15:0]                  delay_reg;
    logic signed [GAIN_W-1:0]     gain_reg;
    logic [SW_CODE_W-1:0]         width_reg;

    // History write pointer and fill count.
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    // Compute stage.
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic                       s1_use_x_reg;
    logic                       s1_use_ram_reg;
    logic                       s1_collide_reg;
    logic [AW-1:0]              s1_waddr_reg;
    logic [SAMPLE_W-1:0]        byp_reg;

    // Output register.
    logic                out_valid_reg;
    result_t             out_reg;

    logic                accept;
    logic                advance;
    logic [AW-1:0]       wp_eff;
    logic [FW-1:0]       fill_eff;
    logic [DW-1:0]       delay_ext;
    logic [DW-1:0]       d_eff;
    logic [DW:0]         rd_sum;
    logic [AW-1:0]       rd_addr;
    logic                use_ram;
    logic                collide;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic signed [SAMPLE_W-1:0] earlier;
    result_t             result;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        wp_eff    = s_tuser[0] ? '0 : wp_reg;
        fill_eff  = s_tuser[0] ? '0 : fill_reg;
        delay_ext = DW'(delay_reg);
        d_eff     = (delay_ext > MAX_D) ? MAX_D : delay_ext;
        use_ram   = (d_eff != '0) && (DW'(fill_eff) >= d_eff);
        if ((DW + 1)'(wp_eff) >= (DW + 1)'(d_eff))
        begin
            rd_sum = (DW + 1)'(wp_eff) - (DW + 1)'(d_eff);
        end
        else
        begin
            rd_sum = (DW + 1)'(wp_eff) + (DW + 1)'(MAX_DELAY) - (DW + 1)'(d_eff);
        end
        rd_addr = rd_sum[AW-1:0];
        // The slot being read is written at this very edge by the sample ahead.
        collide   = advance && (s1_waddr_reg == rd_addr);
        wp_next   = (wp_eff == LAST_ADDR) ? '0 : wp_eff + 1'b1;
        fill_next = (fill_eff == FILL_MAX) ? fill_eff : fill_eff + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            gain_reg  <= '0;
            width_reg <= SW_16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY: delay_reg <= cfg_data;
                CFG_GAIN:  gain_reg  <= $signed(cfg_data);
                CFG_WIDTH: width_reg <= cfg_data[SW_CODE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg       <= $signed(s_tdata);
            s1_use_x_reg   <= (d_eff == '0);
            s1_use_ram_reg <= use_ram;
            s1_collide_reg <= collide;
            s1_waddr_reg   <= wp_eff;
        end
        if (advance)
        begin
            out_reg <= result;
            byp_reg <= result.sample_out;
        end
    end

    fce_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_history (
        .clk   (clk),
        .we    (advance),
        .waddr (s1_waddr_reg),
        .wdata (result.sample_out),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_use_x_reg)
        begin
            earlier = s1_x_reg;
        end
        else if (s1_use_ram_reg)
        begin
            earlier = s1_collide_reg ? $signed(byp_reg) : $signed(ram_rdata);
        end
        else
        begin
            earlier = '0;
        end
    end

    fce_math u_math (
        .x          (s1_x_reg),
        .earlier    (earlier),
        .gain       (gain_reg),
        .width_code (width_reg),
        .result     (result)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.sample_out;
    assign m_tuser[0] = out_reg.clipped;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond history depth");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_ADDR)
        else $error("write pointer beyond history depth");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed beat did not reach the output register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input refused with an empty compute stage");

endmodule

// File: rtl/core/fce_ram.sv
module fce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/fce_math.sv
module fce_math (
    input  logic signed [fce_pkg::SAMPLE_W-1:0]  x,
    input  logic signed [fce_pkg::SAMPLE_W-1:0]  earlier,
    input  logic signed [fce_pkg::GAIN_W-1:0]    gain,
    input  logic        [fce_pkg::SW_CODE_W-1:0] width_code,
    output fce_pkg::result_t                     result
);

    import fce_pkg::*;

    localparam int PROD_W  = SAMPLE_W + GAIN_W;
    localparam int SCALE_W = PROD_W - FRAC_BITS;
    localparam int SUM_W   = SCALE_W + 1;

    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  biased;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lo;
    logic signed [SUM_W-1:0]   hi;
    logic                      over;
    logic                      under;

    always_comb
    begin
        prod = PROD_W'(gain) * PROD_W'(earlier);
        // Round to nearest with ties away from zero: a negative product takes
        // one less than half so that the arithmetic shift mirrors the positive side.
        biased = prod + (prod[PROD_W-1] ? PROD_W'(8191) : PROD_W'(8192));
        scaled = $signed(biased[PROD_W-1:FRAC_BITS]);
        sum = SUM_W'(x) + SUM_W'(scaled);

        unique case (width_code)
            SW_8:
            begin
                lo = -SUM_W'(128);
                hi = SUM_W'(127);
            end
            SW_16:
            begin
                lo = -SUM_W'(32768);
                hi = SUM_W'(32767);
            end
            default:
            begin
                lo = -SUM_W'(64'sd2147483648);
                hi = SUM_W'(64'sd2147483647);
            end
        endcase

        over  = sum > hi;
        under = sum < lo;
        result.clipped = over || under;
        if (over)
        begin
            result.sample_out = hi[SAMPLE_W-1:0];
        end
        else if (under)
        begin
            result.sample_out = lo[SAMPLE_W-1:0];
        end
        else
        begin
            result.sample_out = sum[SAMPLE_W-1:0];
        end
    end

endmodule
